>>> hdl/mcr_pkg.sv
// shared constants and codes for the midpoint circle rasterizer
// no dependencies; imported by every module of the block
package mcr_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int RADIUS_BITS_DEF = 11;

	// depth of the run queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// eight symmetric points per run
	localparam int PTS_PER_RUN = 8;
	localparam int IDX_W       = $clog2(PTS_PER_RUN);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PTS_PER_RUN - 1);

	typedef enum logic {
		OP_START = 1'b0,
		OP_CONT  = 1'b1
	} op_t;

endpackage

>>> hdl/midpoint_circle_rasterizer_unit.sv
// Midpoint circle rasterizer. A start item (tuser = 0) loads center and radius
// and plots the first octant step; each continue item (tuser = 1) plots the
// next step, and a continue while no circle is active produces nothing. Each
// plotted step gives eight points, one per cycle while m_tready does not stall
// the output register. The front takes an item every cycle while its two-entry
// run queue has room, so items may arrive back to back; the first point of a
// run passes through the queue entry and then the output register. tlast marks
// the eighth point of a run and m_tuser marks every point of the circle's
// final run.
// top level; depends on mcr_pkg, mcr_front, mcr_queue and mcr_back
module midpoint_circle_rasterizer_unit #(
	parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
	parameter int S_DATA_W    = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
	parameter int M_DATA_W    = ((2 * (COORD_BITS + 2) + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // center_x, center_y, radius
	input  logic                s_tuser,  // op
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // point_x, point_y
	output logic                m_tlast,
	output logic                m_tuser   // done_res
);
	import mcr_pkg::*;

	localparam int PT_BITS = COORD_BITS + 2;
	localparam int DESC_W  = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

	logic                      q_push, q_pop, q_full, q_empty;
	logic [DESC_W-1:0]         push_desc, head_desc;
	logic signed [PT_BITS-1:0] px, py;
	op_t                       in_op;

	assign in_op = op_t'(s_tuser);

	mcr_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.DESC_W      (DESC_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (in_op),
		.in_cx     (s_tdata[COORD_BITS-1:0]),
		.in_cy     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.in_radius (s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (push_desc)
	);

	mcr_queue #(
		.WIDTH (DESC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_desc),
		.pop       (q_pop),
		.head      (head_desc),
		.empty     (q_empty),
		.full      (q_full)
	);

	mcr_back #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.DESC_W      (DESC_W),
		.PT_BITS     (PT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (head_desc),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_px    (px),
		.out_py    (py),
		.out_last  (m_tlast),
		.out_done  (m_tuser)
	);

	assign m_tdata = M_DATA_W'({py, px});

endmodule

>>> hdl/mcr_front.sv
// front part: accepts start/continue items, keeps the circle state and
// steps the midpoint rule, pushing one run descriptor per plotted run
// depends on mcr_pkg
module mcr_front #(
	parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
	parameter int DESC_W      = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mcr_pkg::op_t           in_op,
	input  logic [COORD_BITS-1:0]  in_cx,
	input  logic [COORD_BITS-1:0]  in_cy,
	input  logic [RADIUS_BITS-1:0] in_radius,
	input  logic                   q_full,
	output logic                   q_push,
	output logic [DESC_W-1:0]      q_desc
);
	import mcr_pkg::*;

	localparam int DEC_BITS = RADIUS_BITS + 4;

	logic [COORD_BITS-1:0]  ctr_x_q, ctr_y_q;
	logic [RADIUS_BITS-1:0] off_x_q, off_y_q;
	logic [DEC_BITS-1:0]    dec_q;
	logic                   active_q;

	logic                   acc, start, fin;
	logic [COORD_BITS-1:0]  cur_h, cur_k;
	logic [RADIUS_BITS-1:0] cur_x, cur_y;
	logic [DEC_BITS-1:0]    cur_d, two_x, two_y, nxt_d;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign start    = (in_op == OP_START);
	// continue while idle is dropped
	assign q_push   = acc && (start || active_q);

	always_comb begin
		cur_h = start ? in_cx : ctr_x_q;
		cur_k = start ? in_cy : ctr_y_q;
		cur_x = start ? '0 : off_x_q;
		cur_y = start ? in_radius : off_y_q;
		cur_d = start ? (DEC_BITS'(1) - DEC_BITS'(in_radius)) : dec_q;
		fin   = !(cur_y > cur_x);
		two_x = DEC_BITS'(cur_x) << 1;
		two_y = DEC_BITS'(cur_y) << 1;
		if (cur_d[DEC_BITS-1]) begin
			nxt_d = cur_d + two_x + DEC_BITS'(3);
		end else begin
			nxt_d = cur_d + two_x - two_y + DEC_BITS'(5);
		end
	end

	assign q_desc = {fin, cur_y, cur_x, cur_k, cur_h};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q  <= '0;
			ctr_y_q  <= '0;
			off_x_q  <= '0;
			off_y_q  <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else if (q_push) begin
			ctr_x_q <= cur_h;
			ctr_y_q <= cur_k;
			if (fin) begin
				active_q <= 1'b0;
				off_x_q  <= cur_x;
				off_y_q  <= cur_y;
				dec_q    <= cur_d;
			end else begin
				active_q <= 1'b1;
				off_x_q  <= cur_x + RADIUS_BITS'(1);
				off_y_q  <= cur_d[DEC_BITS-1] ? cur_y : (cur_y - RADIUS_BITS'(1));
				dec_q    <= nxt_d;
			end
		end
	end

endmodule

>>> hdl/mcr_queue.sv
// short queue of run descriptors between the front and the back
// depends on mcr_pkg
module mcr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);
	import mcr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/mcr_back.sv
// back part: expands the run descriptor at the queue head into its eight
// symmetric points through an output register, one per cycle while
// out_ready does not stall it; depends on mcr_pkg
module mcr_back #(
	parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
	parameter int DESC_W      = 2 * COORD_BITS + 2 * RADIUS_BITS + 1,
	parameter int PT_BITS     = COORD_BITS + 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [DESC_W-1:0]         q_head,
	input  logic                      q_empty,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [PT_BITS-1:0] out_px,
	output logic signed [PT_BITS-1:0] out_py,
	output logic                      out_last,
	output logic                      out_done
);
	import mcr_pkg::*;

	localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

	logic [COORD_BITS-1:0]  h, k;
	logic [RADIUS_BITS-1:0] x, y, a, b;
	logic                   fin;
	logic [SUM_W-1:0]       px_full, py_full;
	logic [IDX_W-1:0]       idx_q;
	logic                   load, emit;

	logic                   valid_q, last_q, done_q;
	logic [PT_BITS-1:0]     px_q, py_q;

	assign h   = q_head[COORD_BITS-1:0];
	assign k   = q_head[2*COORD_BITS-1:COORD_BITS];
	assign x   = q_head[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
	assign y   = q_head[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];
	assign fin = q_head[DESC_W-1];

	// second half of the run swaps the roles of x and y;
	// index bit 0 negates the x offset, bit 1 the y offset
	always_comb begin
		a = idx_q[2] ? y : x;
		b = idx_q[2] ? x : y;
		px_full = idx_q[0] ? (SUM_W'(h) - SUM_W'(a)) : (SUM_W'(h) + SUM_W'(a));
		py_full = idx_q[1] ? (SUM_W'(k) - SUM_W'(b)) : (SUM_W'(k) + SUM_W'(b));
	end

	assign load  = !valid_q || out_ready;
	assign emit  = load && !q_empty;
	assign q_pop = emit && (idx_q == IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			px_q   <= px_full[PT_BITS-1:0];
			py_q   <= py_full[PT_BITS-1:0];
			last_q <= (idx_q == IDX_LAST);
			done_q <= fin;
		end
	end

	assign out_valid = valid_q;
	assign out_px    = px_q;
	assign out_py    = py_q;
	assign out_last  = last_q;
	assign out_done  = done_q;

endmodule

>>> hdl/mcr_checker.sv
// port-level checks on the result stream of the circle rasterizer
// depends on mcr_pkg; bound to midpoint_circle_rasterizer_unit below
module mcr_checker #(
	parameter int M_DATA_W = 32
) (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast,
	input logic                m_tuser
);
	import mcr_pkg::*;

	logic [IDX_W-1:0] beat_q;
	logic             run_done_q;
	logic             out_acc;

	assign out_acc = m_tvalid && m_tready;

	// position of the next point within its run, and the done flag of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q     <= '0;
			run_done_q <= 1'b0;
		end else if (out_acc) begin
			beat_q <= beat_q + IDX_W'(1);
			if (beat_q == '0) begin
				run_done_q <= m_tuser;
			end
		end
	end

	a_last_on_eighth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (beat_q == IDX_LAST)))
		else $error("tlast not on the eighth point of a run");

	a_done_whole_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && beat_q != '0) |-> (m_tuser == run_done_q))
		else $error("done flag changes within a run");

	a_no_out_after_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid right after reset");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result changed");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker #(
	.M_DATA_W (M_DATA_W)
) u_mcr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

>>> tb/testbench.sv
// self-checking testbench for midpoint_circle_rasterizer_unit: an in-bench circle
// predictor fills a queue of expected points that the output monitor checks in order
// depends on mcr_pkg and the rasterizer rtl
`timescale 1ns / 100ps

module testbench;
	import mcr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_LEN       = 400;
	localparam int DRAIN_CYCLES   = 16;

	typedef struct {
		logic [13:0] px;
		logic [13:0] py;
		logic        last;
		logic        done;
	} circle_point_t;

	class circle_scoreboard;
		circle_point_t      points_due[$];
		logic [11:0]        ctr_x, ctr_y;
		logic [10:0]        off_x, off_y;
		logic signed [14:0] decision;
		bit                 drawing;
		int                 errors;

		function new();
			ctr_x = '0;
			ctr_y = '0;
			off_x = '0;
			off_y = '0;
			decision = '0;
			drawing = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// advance the circle state for one accepted item and queue its points
		function void note_item(op_t op, logic [11:0] cx, logic [11:0] cy, logic [10:0] r);
			int h, k, x, y, d, i;
			bit fin;
			int xs[PTS_PER_RUN];
			int ys[PTS_PER_RUN];
			circle_point_t p;
			if (op == OP_START) begin
				ctr_x = cx;
				ctr_y = cy;
				off_x = '0;
				off_y = r;
				decision = 15'(1 - int'(r));
				drawing = 1;
			end else if (!drawing) begin
				return;
			end
			h = ctr_x;
			k = ctr_y;
			x = off_x;
			y = off_y;
			fin = !(y > x);
			xs = '{h + x, h - x, h + x, h - x, h + y, h - y, h + y, h - y};
			ys = '{k + y, k + y, k - y, k - y, k + x, k + x, k - x, k - x};
			for (i = 0; i < PTS_PER_RUN; i++) begin
				p.px = 14'(xs[i]);
				p.py = 14'(ys[i]);
				p.last = (i == PTS_PER_RUN - 1);
				p.done = fin;
				points_due.push_back(p);
			end
			if (fin) begin
				drawing = 0;
			end else begin
				d = decision;
				if (d < 0) begin
					d += 2 * x + 3;
				end else begin
					d += 2 * (x - y) + 5;
					y -= 1;
				end
				x += 1;
				decision = 15'(d);
				off_x = 11'(x);
				off_y = 11'(y);
			end
		endfunction

		task check_point(logic [13:0] px, logic [13:0] py, logic last, logic done);
			circle_point_t w;
			if (points_due.size() == 0) begin
				report($sformatf("point (%0d,%0d) with nothing expected", $signed(px),
					$signed(py)));
				return;
			end
			w = points_due.pop_front();
			if (px !== w.px)
				report($sformatf("point_x got %0d want %0d", $signed(px), $signed(w.px)));
			if (py !== w.py)
				report($sformatf("point_y got %0d want %0d", $signed(py), $signed(w.py)));
			if (last !== w.last)
				report($sformatf("tlast got %b want %b", last, w.last));
			if (done !== w.done)
				report($sformatf("done got %b want %b", done, w.done));
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	circle_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holds_asked    = 0;
	int holds_given    = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	midpoint_circle_rasterizer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_asked != holds_given) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_LEN;
			holds_given <= holds_given + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_point(m_tdata[13:0], m_tdata[27:14], m_tlast, m_tuser);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	task automatic send_item(op_t op, logic [11:0] cx, logic [11:0] cy, logic [10:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'b0, r, cy, cx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(op, cx, cy, r);
	endtask

	task automatic finish_circle();
		while (sb.drawing)
			send_item(OP_CONT, 12'($urandom), 12'($urandom), 11'($urandom));
	endtask

	function automatic logic [10:0] pick_radius();
		int sel;
		sel = $urandom_range(99);
		if (sel < 80)
			return 11'($urandom_range(16));
		else if (sel < 95)
			return 11'($urandom_range(120, 17));
		return 11'($urandom);
	endfunction

	// mostly whole circles with random centers; some abandoned, some stray continues
	task automatic random_circles(int n);
		int made;
		int sel;
		made = 0;
		while (made < n) begin
			sel = $urandom_range(99);
			if (!sb.drawing && sel < 8) begin
				send_item(OP_CONT, 12'($urandom), 12'($urandom), 11'($urandom));
			end else if (!sb.drawing || sel < 4) begin
				send_item(OP_START, 12'($urandom), 12'($urandom), pick_radius());
				made++;
			end else begin
				send_item(OP_CONT, 12'($urandom), 12'($urandom), 11'($urandom));
				made++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: idle continues, zero radius, smallest circle,
		// largest radius at both center extremes, restart while drawing
		send_item(OP_CONT, 12'hfff, 12'hfff, 11'h7ff);
		send_item(OP_START, 12'hfff, 12'hfff, 11'd0);
		send_item(OP_CONT, 12'h000, 12'h000, 11'h000);
		send_item(OP_START, 12'h000, 12'h000, 11'd0);
		send_item(OP_START, 12'h000, 12'hfff, 11'd1);
		finish_circle();
		send_item(OP_CONT, 12'haaa, 12'h555, 11'h2aa);
		send_item(OP_START, 12'h000, 12'h000, 11'h7ff);
		repeat (3) send_item(OP_CONT, 12'h555, 12'haaa, 11'h555);
		send_item(OP_START, 12'hfff, 12'hfff, 11'h7ff);
		repeat (2) send_item(OP_CONT, 12'h000, 12'h000, 11'h000);
		send_item(OP_START, 12'haaa, 12'h555, 11'd5);
		finish_circle();
		send_item(OP_START, 12'h555, 12'haaa, 11'd3);
		finish_circle();

		// long receiver hold-off while items keep coming
		holds_asked++;
		random_circles(20);

		send_idle_pct = 79;
		recv_stall_pct = 0;
		random_circles(40);
		send_idle_pct = 0;
		recv_stall_pct = 79;
		random_circles(40);
		send_idle_pct = 19;
		recv_stall_pct = 19;
		random_circles(40);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_circles(40);

		s_tvalid <= 1'b0;
		while (sb.points_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hdl/mcr_pkg.sv
hdl/mcr_front.sv
hdl/mcr_queue.sv
hdl/mcr_back.sv
hdl/midpoint_circle_rasterizer_unit.sv
hdl/mcr_checker.sv
tb/testbench.sv
